// ----- rtl/core/roc_pkg.sv -----
package roc_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_JOBS_DEF   = 64;
	localparam int NUM_RES_DEF    = 4;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed port widths.
	localparam int RES_PORTS = 4;
	localparam int CNT_W     = 7;
	localparam int JOB_W     = 6;
	localparam int FIELD_W   = 16;
	localparam int SET_W     = 64;

	// Reset values of the registers.
	localparam int JOB_COUNT_RST = 64;
	localparam int CAP_RST       = 65535;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_JOB_COUNT = 3'd0;
	localparam logic [2:0] REG_CAP0      = 3'd1;
	localparam logic [2:0] REG_CAP1      = 3'd2;
	localparam logic [2:0] REG_CAP2      = 3'd3;
	localparam logic [2:0] REG_CAP3      = 3'd4;

	// Command codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

endpackage

// ----- rtl/core/roc_cell.sv -----
module roc_cell #(
	parameter int MAX_JOBS      = 64,
	parameter int NUM_RESOURCES = 4,
	parameter int VALUE_BITS    = 16,
	parameter int CELL_ID       = 0
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  logic                                                       ld_en,
	input  logic [VALUE_BITS-1:0]                                      ld_start,
	input  logic [VALUE_BITS-1:0]                                      ld_dur,
	input  logic [NUM_RESOURCES*VALUE_BITS-1:0]                        ld_dem,
	input  logic [roc_pkg::CNT_W-1:0]                                  last_idx,
	input  logic                                                       v_in,
	input  logic [VALUE_BITS-1:0]                                      t_in,
	input  logic [$clog2(MAX_JOBS)-1:0]                                idx_in,
	input  logic [MAX_JOBS-1:0]                                        set_in,
	input  logic [NUM_RESOURCES*(VALUE_BITS+$clog2(MAX_JOBS))-1:0]     sum_in,
	output logic                                                       v_out,
	output logic [VALUE_BITS-1:0]                                      t_out,
	output logic [$clog2(MAX_JOBS)-1:0]                                idx_out,
	output logic [MAX_JOBS-1:0]                                        set_out,
	output logic [NUM_RESOURCES*(VALUE_BITS+$clog2(MAX_JOBS))-1:0]     sum_out
);
	import roc_pkg::*;

	localparam int JW = $clog2(MAX_JOBS);
	localparam int SW = VALUE_BITS + JW;
	localparam logic [MAX_JOBS-1:0] OWN_BIT = MAX_JOBS'(1) << CELL_ID;

	logic [VALUE_BITS-1:0]               start_q;
	logic [VALUE_BITS-1:0]               dur_q;
	logic [NUM_RESOURCES*VALUE_BITS-1:0] dem_q;
	logic                                in_range;
	logic                                runs;
	logic                                act;

	always_ff @(posedge clk) begin
		if (ld_en) begin
			start_q <= ld_start;
			dur_q   <= ld_dur;
			dem_q   <= ld_dem;
		end
	end

	// A real job runs at instant t when it started at or before t and ends after t.
	always_comb begin
		in_range = (CELL_ID >= 1) && (CNT_W'(CELL_ID) <= last_idx);
		runs     = ({1'b0, start_q} <= {1'b0, t_in}) &&
		           (({1'b0, start_q} + {1'b0, dur_q}) > {1'b0, t_in});
		act      = (idx_in == JW'(CELL_ID)) || (in_range && runs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		t_out   <= t_in;
		idx_out <= idx_in;
		set_out <= act ? (set_in | OWN_BIT) : set_in;
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			sum_out[k*SW +: SW] <= sum_in[k*SW +: SW] +
				(act ? SW'(dem_q[k*VALUE_BITS +: VALUE_BITS]) : SW'(0));
		end
	end

endmodule

// ----- rtl/core/roc_judge.sv -----
module roc_judge #(
	parameter int MAX_JOBS      = 64,
	parameter int NUM_RESOURCES = 4,
	parameter int VALUE_BITS    = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   clr,
	input  logic [roc_pkg::CNT_W-1:0]                              last_idx,
	input  logic [NUM_RESOURCES*VALUE_BITS-1:0]                    cap_flat,
	input  logic                                                   v_in,
	input  logic [$clog2(MAX_JOBS)-1:0]                            idx_in,
	input  logic [MAX_JOBS-1:0]                                    set_in,
	input  logic [NUM_RESOURCES*(VALUE_BITS+$clog2(MAX_JOBS))-1:0] sum_in,
	output logic                                                   result_valid,
	output logic [roc_pkg::JOB_W-1:0]                              checked_job,
	output logic [roc_pkg::SET_W-1:0]                              active_set,
	output logic [roc_pkg::RES_PORTS-1:0]                          overload_mask,
	output logic                                                   any_overload,
	output logic                                                   last
);
	import roc_pkg::*;

	localparam int JW = $clog2(MAX_JOBS);
	localparam int SW = VALUE_BITS + JW;

	logic [RES_PORTS-1:0] mask;
	logic                 any_q;
	logic                 any_new;

	always_comb begin
		mask = '0;
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			mask[k] = sum_in[k*SW +: SW] > SW'(cap_flat[k*VALUE_BITS +: VALUE_BITS]);
		end
		any_new = any_q | (|mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			any_q        <= 1'b0;
		end else begin
			result_valid <= v_in;
			if (clr) begin
				any_q <= 1'b0;
			end else if (v_in) begin
				any_q <= any_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_in) begin
			checked_job   <= JOB_W'(idx_in);
			active_set    <= SET_W'(set_in);
			overload_mask <= mask;
			any_overload  <= any_new;
			last          <= (CNT_W'(idx_in) == last_idx);
		end
	end

endmodule

// ----- rtl/core/resource_overload_check.sv -----
// Resource overload check.
//
// Jobs are written one per transfer on the command channel: start with
// opcode LOAD stores job_index's start time, duration and demands in the
// cell of that job. A load yields no result. A transfer with opcode CHECK
// walks the real jobs 1 .. n-2, n being job_count clipped to MAX_JOBS. The
// jobs are issued into a row of MAX_JOBS cells, one per cycle; each query
// moves one cell per cycle, and each cell adds its job to the running set
// and demand sums when it is the queried job or runs at the queried instant.
// A final stage compares the sums with the capacity registers. The first
// result leaves the result register after the sequencer, the start-time
// read and the cell row; then one result per cycle follows, n-2 in all, in
// job order, each shown for one cycle with result_valid. busy stays high
// from the check transfer until the result marked last has been shown. A
// check with job_count below 3 yields nothing and does not raise busy.
// The receiver cannot stall, so the chain never stops once it starts.
// Reset clears the control state and sets job_count to 64 and every
// capacity to 65535; the job store holds nothing defined until loaded.
// Configuration goes through the APB port, registers at byte address 4*i.
module resource_overload_check #(
	parameter int MAX_JOBS      = roc_pkg::MAX_JOBS_DEF,
	parameter int NUM_RESOURCES = roc_pkg::NUM_RES_DEF,
	parameter int VALUE_BITS    = roc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [roc_pkg::JOB_W-1:0]     job_index,
	input  logic [roc_pkg::FIELD_W-1:0]   start_time,
	input  logic [roc_pkg::FIELD_W-1:0]   duration,
	input  logic [roc_pkg::FIELD_W-1:0]   demand_0,
	input  logic [roc_pkg::FIELD_W-1:0]   demand_1,
	input  logic [roc_pkg::FIELD_W-1:0]   demand_2,
	input  logic [roc_pkg::FIELD_W-1:0]   demand_3,
	output logic                          result_valid,
	output logic [roc_pkg::JOB_W-1:0]     checked_job,
	output logic [roc_pkg::SET_W-1:0]     active_set,
	output logic [roc_pkg::RES_PORTS-1:0] overload_mask,
	output logic                          any_overload,
	output logic                          last
);
	import roc_pkg::*;

	localparam int JW = $clog2(MAX_JOBS);
	localparam int SW = VALUE_BITS + JW;
	localparam int DW = NUM_RESOURCES * VALUE_BITS;
	localparam int AW = NUM_RESOURCES * SW;

	// Configuration registers.
	logic [CNT_W-1:0]      job_count_q;
	logic [VALUE_BITS-1:0] cap_q [RES_PORTS];
	logic [2:0]            reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= CNT_W'(JOB_COUNT_RST);
			for (int k = 0; k < RES_PORTS; k++) begin
				cap_q[k] <= VALUE_BITS'(CAP_RST);
			end
		end else if (wr_en) begin
			case (reg_idx)
				REG_JOB_COUNT: job_count_q <= pwdata[CNT_W-1:0];
				REG_CAP0:      cap_q[0] <= VALUE_BITS'(pwdata[FIELD_W-1:0]);
				REG_CAP1:      cap_q[1] <= VALUE_BITS'(pwdata[FIELD_W-1:0]);
				REG_CAP2:      cap_q[2] <= VALUE_BITS'(pwdata[FIELD_W-1:0]);
				REG_CAP3:      cap_q[3] <= VALUE_BITS'(pwdata[FIELD_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_JOB_COUNT: prdata = 32'(job_count_q);
			REG_CAP0:      prdata = 32'(cap_q[0]);
			REG_CAP1:      prdata = 32'(cap_q[1]);
			REG_CAP2:      prdata = 32'(cap_q[2]);
			REG_CAP3:      prdata = 32'(cap_q[3]);
			default:       prdata = 32'd0;
		endcase
	end

	// Job count clipped to the size of the cell row; the last real job sits two
	// below it.
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] last_idx;
	logic             check_ok;

	always_comb begin
		n_eff    = (job_count_q > CNT_W'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : job_count_q;
		last_idx = n_eff - CNT_W'(2);
		check_ok = n_eff >= CNT_W'(3);
	end

	// Command transfers.
	logic busy_q;
	logic cmd_acc;
	logic load_acc;
	logic chk_acc;

	assign busy     = busy_q;
	assign cmd_acc  = start && !busy_q;
	assign load_acc = cmd_acc && (opcode == OP_LOAD) &&
	                  (CNT_W'(job_index) < CNT_W'(MAX_JOBS));
	assign chk_acc  = cmd_acc && (opcode == OP_CHECK);

	// Issue sequencer: one query per cycle for jobs 1 .. last_idx.
	logic          iss_q;
	logic [JW-1:0] iss_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			iss_q     <= 1'b0;
			iss_idx_q <= '0;
		end else if (chk_acc && check_ok) begin
			busy_q    <= 1'b1;
			iss_q     <= 1'b1;
			iss_idx_q <= JW'(1);
		end else begin
			if (iss_q) begin
				if (CNT_W'(iss_idx_q) == last_idx) begin
					iss_q <= 1'b0;
				end else begin
					iss_idx_q <= iss_idx_q + JW'(1);
				end
			end
			if (result_valid && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Copy of the start times, read by the sequencer to get each query's
	// instant. The cells keep their own copy for the comparisons.
	logic [VALUE_BITS-1:0] start_mem [MAX_JOBS];
	logic [VALUE_BITS-1:0] t_s1;
	logic [JW-1:0]         idx_s1;
	logic                  v_s1;

	always_ff @(posedge clk) begin
		if (load_acc) begin
			start_mem[job_index[JW-1:0]] <= VALUE_BITS'(start_time);
		end
		t_s1   <= start_mem[iss_idx_q];
		idx_s1 <= iss_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= iss_q;
		end
	end

	// Load data, trimmed to the value width.
	logic [FIELD_W-1:0] dem_in [RES_PORTS];
	logic [DW-1:0]      ld_dem;
	logic [DW-1:0]      cap_flat;

	assign dem_in[0] = demand_0;
	assign dem_in[1] = demand_1;
	assign dem_in[2] = demand_2;
	assign dem_in[3] = demand_3;

	always_comb begin
		for (int k = 0; k < NUM_RESOURCES; k++) begin
			ld_dem[k*VALUE_BITS +: VALUE_BITS]   = VALUE_BITS'(dem_in[k]);
			cap_flat[k*VALUE_BITS +: VALUE_BITS] = cap_q[k];
		end
	end

	// The cell row. Link c feeds cell c; link MAX_JOBS feeds the final stage.
	logic                  v_c   [MAX_JOBS+1];
	logic [VALUE_BITS-1:0] t_c   [MAX_JOBS+1];
	logic [JW-1:0]         idx_c [MAX_JOBS+1];
	logic [MAX_JOBS-1:0]   set_c [MAX_JOBS+1];
	logic [AW-1:0]         sum_c [MAX_JOBS+1];

	assign v_c[0]   = v_s1;
	assign t_c[0]   = t_s1;
	assign idx_c[0] = idx_s1;
	assign set_c[0] = '0;
	assign sum_c[0] = '0;

	for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
		logic ld_en;

		assign ld_en = load_acc && (job_index[JW-1:0] == JW'(g));

		roc_cell #(
			.MAX_JOBS      (MAX_JOBS),
			.NUM_RESOURCES (NUM_RESOURCES),
			.VALUE_BITS    (VALUE_BITS),
			.CELL_ID       (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld_en    (ld_en),
			.ld_start (VALUE_BITS'(start_time)),
			.ld_dur   (VALUE_BITS'(duration)),
			.ld_dem   (ld_dem),
			.last_idx (last_idx),
			.v_in     (v_c[g]),
			.t_in     (t_c[g]),
			.idx_in   (idx_c[g]),
			.set_in   (set_c[g]),
			.sum_in   (sum_c[g]),
			.v_out    (v_c[g+1]),
			.t_out    (t_c[g+1]),
			.idx_out  (idx_c[g+1]),
			.set_out  (set_c[g+1]),
			.sum_out  (sum_c[g+1])
		);
	end

	// Capacity compare and result register. The running overload flag restarts
	// with every check transfer.
	roc_judge #(
		.MAX_JOBS      (MAX_JOBS),
		.NUM_RESOURCES (NUM_RESOURCES),
		.VALUE_BITS    (VALUE_BITS)
	) u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.clr           (chk_acc),
		.last_idx      (last_idx),
		.cap_flat      (cap_flat),
		.v_in          (v_c[MAX_JOBS]),
		.idx_in        (idx_c[MAX_JOBS]),
		.set_in        (set_c[MAX_JOBS]),
		.sum_in        (sum_c[MAX_JOBS]),
		.result_valid  (result_valid),
		.checked_job   (checked_job),
		.active_set    (active_set),
		.overload_mask (overload_mask),
		.any_overload  (any_overload),
		.last          (last)
	);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

// Testbench for resource_overload_check.
// An initial block plans the stimulus phase by phase. It programs the
// registers over APB while the block is idle and fills the command queue.
// A driver on the falling clock edge feeds one transfer at a time from that
// queue. A monitor on the rising clock edge does three jobs. It mirrors each
// accepted load into a local copy of the job store. For each accepted check
// it works out the results the block should produce. It compares every
// result strobe, field by field, with the oldest result still owed.
module tb;
	import roc_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int DRAIN_CYCLES  = MAX_JOBS_DEF + 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int ITEM_TARGET   = 310;
	localparam int WINDOW_SPAN   = 120;
	// Writes to this index must be ignored by the block.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic               op;
		logic [JOB_W-1:0]   idx;
		logic [FIELD_W-1:0] st;
		logic [FIELD_W-1:0] du;
		logic [FIELD_W-1:0] d0;
		logic [FIELD_W-1:0] d1;
		logic [FIELD_W-1:0] d2;
		logic [FIELD_W-1:0] d3;
	} job_cmd_t;

	typedef struct packed {
		logic [JOB_W-1:0]     job;
		logic [SET_W-1:0]     members;
		logic [RES_PORTS-1:0] mask;
		logic                 flagged;
		logic                 is_last;
	} overload_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic opcode = OP_LOAD;
	logic [JOB_W-1:0] job_index = '0;
	logic [FIELD_W-1:0] start_time = '0;
	logic [FIELD_W-1:0] duration = '0;
	logic [FIELD_W-1:0] demand_0 = '0;
	logic [FIELD_W-1:0] demand_1 = '0;
	logic [FIELD_W-1:0] demand_2 = '0;
	logic [FIELD_W-1:0] demand_3 = '0;
	logic result_valid;
	logic [JOB_W-1:0] checked_job;
	logic [SET_W-1:0] active_set;
	logic [RES_PORTS-1:0] overload_mask;
	logic any_overload;
	logic last;

	// Commands waiting to be driven, and results the block still owes.
	job_cmd_t job_cmds[$];
	overload_rec_t owed_results[$];
	job_cmd_t next_cmd;

	// Local copy of the register file and of the job store.
	logic [CNT_W-1:0] cfg_jobs = CNT_W'(JOB_COUNT_RST);
	logic [FIELD_W-1:0] cfg_cap [RES_PORTS];
	logic [FIELD_W-1:0] job_start [MAX_JOBS_DEF];
	logic [FIELD_W-1:0] job_len [MAX_JOBS_DEF];
	logic [FIELD_W-1:0] job_need [RES_PORTS][MAX_JOBS_DEF];

	// Jobs that the queued commands will have loaded; a check is only queued
	// once every real job it walks has been written.
	logic [MAX_JOBS_DEF-1:0] planned_loads = '0;

	int items_queued = 0;
	int items_accepted = 0;
	int mismatches = 0;
	int stall_cycles = 0;
	int gap_pct = 13;
	int window_base = 0;
	logic took_cmd = 1'b0;

	resource_overload_check DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.job_index(job_index),
		.start_time(start_time),
		.duration(duration),
		.demand_0(demand_0),
		.demand_1(demand_1),
		.demand_2(demand_2),
		.demand_3(demand_3),
		.result_valid(result_valid),
		.checked_job(checked_job),
		.active_set(active_set),
		.overload_mask(overload_mask),
		.any_overload(any_overload),
		.last(last)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < RES_PORTS; k++) begin
			cfg_cap[k] = FIELD_W'(CAP_RST);
		end
	end

	// Compares one field and reports a difference. Used for result fields
	// and for register read-back alike.
	function automatic void compare_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endfunction

	// Works out the results of a check from the local job store. Each real
	// job's start instant is examined: the job itself always counts, and any
	// other real job counts when it has started by then and has not yet
	// ended. The end time is taken one bit wider so that it never wraps.
	// Demand sums are wide enough for every real job at full demand.
	function automatic void forecast_check();
		int n;
		logic [SET_W-1:0] members;
		logic [FIELD_W:0] stop_at;
		logic [23:0] total;
		logic [RES_PORTS-1:0] mask;
		logic flagged;
		overload_rec_t rec;
		n = (cfg_jobs > CNT_W'(MAX_JOBS_DEF)) ? MAX_JOBS_DEF : int'(cfg_jobs);
		flagged = 1'b0;
		for (int i = 1; i + 1 < n; i++) begin
			members = '0;
			members[i] = 1'b1;
			for (int j = 1; j + 1 < n; j++) begin
				stop_at = {1'b0, job_start[j]} + {1'b0, job_len[j]};
				if (j != i && job_start[j] <= job_start[i] &&
						stop_at > {1'b0, job_start[i]})
					members[j] = 1'b1;
			end
			mask = '0;
			for (int k = 0; k < NUM_RES_DEF; k++) begin
				total = '0;
				for (int j = 1; j + 1 < n; j++) begin
					if (members[j])
						total += 24'(job_need[k][j]);
				end
				if (total > 24'(cfg_cap[k]))
					mask[k] = 1'b1;
			end
			if (mask != '0)
				flagged = 1'b1;
			rec.job = JOB_W'(i);
			rec.members = members;
			rec.mask = mask;
			rec.flagged = flagged;
			rec.is_last = (i + 2 == n);
			owed_results = {owed_results, rec};
		end
	endfunction

	// Driver. A new command goes out only when the slot is free, that is
	// when start is low or the previous command was taken at the last rising
	// edge. A random share of free slots is left empty to open gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took_cmd) begin
			if (job_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
				next_cmd = job_cmds.pop_front();
				start <= 1'b1;
				opcode <= next_cmd.op;
				job_index <= next_cmd.idx;
				start_time <= next_cmd.st;
				duration <= next_cmd.du;
				demand_0 <= next_cmd.d0;
				demand_1 <= next_cmd.d1;
				demand_2 <= next_cmd.d2;
				demand_3 <= next_cmd.d3;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. Inputs were set up at the falling edge, so at the rising edge
	// they and the block's outputs are stable. A command transfer happens
	// when start is high and busy is low. A result transfer happens whenever
	// result_valid is high, since the receiver cannot stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			took_cmd <= 1'b0;
		end else begin
			took_cmd <= start && !busy;
			if (start && !busy) begin
				items_accepted <= items_accepted + 1;
				if (opcode == OP_LOAD) begin
					job_start[job_index] = start_time;
					job_len[job_index] = duration;
					job_need[0][job_index] = demand_0;
					job_need[1][job_index] = demand_1;
					job_need[2][job_index] = demand_2;
					job_need[3][job_index] = demand_3;
				end else begin
					forecast_check();
				end
			end
			if (result_valid) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none, got job %0d",
						$time, checked_job);
				end else begin
					compare_field("checked_job", 64'(owed_results[0].job), 64'(checked_job));
					compare_field("active_set", owed_results[0].members, active_set);
					compare_field("overload_mask", 64'(owed_results[0].mask),
						64'(overload_mask));
					compare_field("any_overload", 64'(owed_results[0].flagged),
						64'(any_overload));
					compare_field("last", 64'(owed_results[0].is_last), 64'(last));
					void'(owed_results.pop_front());
				end
			end
		end
	end

	// Watchdog. It counts cycles with no command transfer and no owed result;
	// a stuck busy, a missing result or a stuck strobe ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (result_valid && owed_results.size() != 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("resource_overload_check verification failed");
			$finish;
		end
	end

	// One APB transfer: a setup phase, then an access phase that completes
	// at the rising edge where pready is high.
	task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register, updates the local copy and reads a defined register back.
	// Bits above the register's width carry junk and must be dropped.
	task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] held;
		apb_xfer(1'b1, idx, value, readback);
		if (idx == REG_JOB_COUNT)
			cfg_jobs = value[CNT_W-1:0];
		else if (idx <= REG_CAP3)
			cfg_cap[idx - REG_CAP0] = value[FIELD_W-1:0];
		if (idx <= REG_CAP3) begin
			held = (idx == REG_JOB_COUNT) ? 32'(cfg_jobs) : 32'(cfg_cap[idx - REG_CAP0]);
			apb_xfer(1'b0, idx, $urandom, readback);
			compare_field("register read-back", 64'(held), 64'(readback));
		end
	endtask

	task automatic configure(input int jobs, input int c0, input int c1, input int c2,
			input int c3);
		program_reg(REG_JOB_COUNT, ($urandom & ~32'h7F) | 32'(jobs));
		program_reg(REG_CAP0, ($urandom & 32'hFFFF_0000) | 32'(c0));
		program_reg(REG_CAP1, ($urandom & 32'hFFFF_0000) | 32'(c1));
		program_reg(REG_CAP2, ($urandom & 32'hFFFF_0000) | 32'(c2));
		program_reg(REG_CAP3, ($urandom & 32'hFFFF_0000) | 32'(c3));
	endtask

	// Waits until every queued command has been taken and every owed result
	// has arrived, then lets a load that is still in flight settle.
	task automatic wait_idle();
		while (items_accepted != items_queued || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_cmd(input job_cmd_t c);
		if (c.op == OP_LOAD)
			planned_loads[c.idx] = 1'b1;
		job_cmds = {job_cmds, c};
		items_queued++;
	endtask

	task automatic queue_load(input int idx, input int st, input int du, input int d0,
			input int d1, input int d2, input int d3);
		job_cmd_t c;
		c = {OP_LOAD, JOB_W'(idx), FIELD_W'(st), FIELD_W'(du), FIELD_W'(d0), FIELD_W'(d1),
			FIELD_W'(d2), FIELD_W'(d3)};
		queue_cmd(c);
	endtask

	function automatic logic [FIELD_W-1:0] pick_need();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 30)
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(3000));
	endfunction

	// Random job contents. Most jobs start inside a narrow window so that
	// they overlap; the rest spread over the whole time range.
	function automatic job_cmd_t random_job(input int idx);
		job_cmd_t c;
		int r;
		c.op = OP_LOAD;
		c.idx = JOB_W'(idx);
		if ($urandom_range(99) < 75)
			c.st = FIELD_W'(window_base + $urandom_range(WINDOW_SPAN));
		else
			c.st = FIELD_W'($urandom);
		r = $urandom_range(99);
		if (r < 8)
			c.du = '0;
		else if (r < 16)
			c.du = '1;
		else if (r < 26)
			c.du = FIELD_W'($urandom);
		else
			c.du = FIELD_W'($urandom_range(160, 1));
		c.d0 = pick_need();
		c.d1 = pick_need();
		c.d2 = pick_need();
		c.d3 = pick_need();
		return c;
	endfunction

	// Queues a check. Any real job not yet written gets a random load first,
	// so the block never reads an empty entry. The data fields of a check are
	// don't-care and carry random junk.
	task automatic queue_check();
		int n;
		job_cmd_t c;
		n = (cfg_jobs > CNT_W'(MAX_JOBS_DEF)) ? MAX_JOBS_DEF : int'(cfg_jobs);
		for (int j = 1; j + 1 < n; j++) begin
			if (!planned_loads[j])
				queue_cmd(random_job(j));
		end
		c = random_job($urandom_range(MAX_JOBS_DEF - 1));
		c.op = OP_CHECK;
		queue_cmd(c);
	endtask

	function automatic int pick_cap();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 65535;
		if (r < 40)
			return 0;
		return $urandom_range(12000);
	endfunction

	function automatic int pick_jobs();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return $urandom_range(2);
		if (r < 20)
			return $urandom_range(127, MAX_JOBS_DEF);
		if (r < 40)
			return $urandom_range(MAX_JOBS_DEF - 1, 13);
		return $urandom_range(12, 3);
	endfunction

	initial begin
		int phase;
		int n_eff;
		int r;
		int jobs;
		phase = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Directed part. Two real jobs with capacities at both extremes and
		// next to them. Slot 0 gets all-zero and slot MAX_JOBS_DEF-1 all-one contents.
		configure(4, 0, 65535, 1, 65534);
		program_reg(REG_UNUSED, 32'hFFFF_FFFF);
		queue_load(0, 0, 0, 0, 0, 0, 0);
		queue_load(MAX_JOBS_DEF - 1, 65535, 65535, 65535, 65535, 65535, 65535);
		// Job 1 ends exactly at job 2's start, so it must not count there;
		// job 2 has zero duration.
		queue_load(1, 0, 65535, 65535, 0, 1, 65535);
		queue_load(2, 65535, 0, 0, 65535, 65535, 0);
		queue_check();
		// Both jobs start at the last instant; job 1's end lies past the
		// 16-bit range and must not wrap.
		queue_load(1, 65535, 65535, 65535, 65535, 65535, 65535);
		queue_check();
		// Job counts too small for any real job: the check yields nothing.
		for (int j = 0; j < 3; j++) begin
			wait_idle();
			program_reg(REG_JOB_COUNT, 32'(j));
			queue_check();
		end
		// The smallest real set: one job.
		wait_idle();
		program_reg(REG_JOB_COUNT, 32'd3);
		queue_check();
		// Three jobs, all sharing a start instant.
		wait_idle();
		configure(5, 65535, 0, 100, 65535);
		queue_load(3, 65535, 1, 50, 0, 60, 1);
		queue_load(2, 65535, 3, 60, 1, 41, 65535);
		queue_check();
		queue_check();

		// Random part, one register setting per phase. The sender idles
		// lightly first, then heavily, then not at all.
		while (items_queued < ITEM_TARGET) begin
			wait_idle();
			gap_pct = (items_queued < 105) ? 13 : (items_queued < 210) ? 80 : 0;
			phase++;
			window_base = $urandom_range(65535 - WINDOW_SPAN);
			if (phase == 1)
				configure(MAX_JOBS_DEF, 65535, 65535, 65535, 65535);
			else if (phase == 2)
				configure(pick_jobs(), 0, 0, 0, 0);
			else if (phase == 5)
				configure(127, pick_cap(), pick_cap(), pick_cap(), pick_cap());
			else
				configure(pick_jobs(), pick_cap(), pick_cap(), pick_cap(), pick_cap());
			n_eff = (cfg_jobs > CNT_W'(MAX_JOBS_DEF)) ? MAX_JOBS_DEF : int'(cfg_jobs);
			repeat ($urandom_range(6, 3)) begin
				r = $urandom_range(99);
				if (r < 70 && n_eff >= 3) begin
					// Refresh a few real jobs, then check.
					jobs = $urandom_range((n_eff - 2 < 6) ? n_eff - 2 : 6, 1);
					repeat (jobs) queue_cmd(random_job($urandom_range(n_eff - 2, 1)));
					queue_check();
				end else if (r < 85) begin
					// Stray load to any slot, dummies and unused slots included.
					queue_cmd(random_job($urandom_range(MAX_JOBS_DEF - 1)));
				end else begin
					queue_check();
				end
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("resource_overload_check verification clean");
		else
			$display("resource_overload_check verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/roc_pkg.sv
rtl/core/roc_cell.sv
rtl/core/roc_judge.sv
rtl/core/resource_overload_check.sv
sim/tb.sv
